>>> src/mrg_pkg.sv
// mrg_pkg: constants, codes and control/status types of the maze row generator.
// Used by the channel interfaces, the controller, the datapath and the top level.
package mrg_pkg;

	localparam int COLUMNS = 16;
	localparam int OP_W    = 2;
	localparam int EAST_W  = 15;
	localparam int SOUTH_W = 16;
	localparam int PICK_W  = 4;
	localparam int LAB_W   = $clog2(COLUMNS);
	localparam int CNT_W   = $clog2(COLUMNS + 1);
	localparam int MOD_W   = (PICK_W > CNT_W) ? PICK_W : CNT_W;

	localparam logic [OP_W-1:0] OP_FIRST  = 2'd0;
	localparam logic [OP_W-1:0] OP_MIDDLE = 2'd1;
	localparam logic [OP_W-1:0] OP_LAST   = 2'd2;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_FRESH,
		CMD_EAST,
		CMD_JOIN,
		CMD_SOUTH,
		CMD_MOD,
		CMD_FINISH
	} cmd_code_t;

	typedef struct packed {
		cmd_code_t        code;
		logic [CNT_W-1:0] col;
	} ctrl_cmd_t;

	typedef struct packed {
		logic first_row;
		logic last_row;
		logic merge;     // wall at col opens this cycle
		logic fallback;  // run ends at col with no opening
		logic mod_ge;    // remainder still >= run length
		logic out_free;
	} dp_status_t;

	// coin bits beyond the field read as zero
	function automatic logic [COLUMNS-2:0] widen_east(input logic [EAST_W-1:0] x);
		logic [COLUMNS-2:0] v;
		v = '0;
		for (int i = 0; i < COLUMNS - 1; i++) begin
			if (i < EAST_W) v[i] = x[i];
		end
		return v;
	endfunction

	function automatic logic [COLUMNS-1:0] widen_south(input logic [SOUTH_W-1:0] x);
		logic [COLUMNS-1:0] v;
		v = '0;
		for (int i = 0; i < COLUMNS; i++) begin
			if (i < SOUTH_W) v[i] = x[i];
		end
		return v;
	endfunction

	function automatic logic [EAST_W-1:0] narrow_east(input logic [COLUMNS-2:0] x);
		logic [EAST_W-1:0] v;
		v = '0;
		for (int i = 0; i < EAST_W; i++) begin
			if (i < COLUMNS - 1) v[i] = x[i];
		end
		return v;
	endfunction

	function automatic logic [SOUTH_W-1:0] narrow_south(input logic [COLUMNS-1:0] x);
		logic [SOUTH_W-1:0] v;
		v = '0;
		for (int i = 0; i < SOUTH_W; i++) begin
			if (i < COLUMNS) v[i] = x[i];
		end
		return v;
	endfunction

endpackage

>>> src/mrg_if.sv
// mrg_if: valid/ready channel interfaces for row requests and carved rows.
// Depends on mrg_pkg for the field widths.
interface mrg_in_if;
	logic                         valid;
	logic                         ready;
	logic [mrg_pkg::OP_W-1:0]     operation;
	logic [mrg_pkg::EAST_W-1:0]   east_coins;
	logic [mrg_pkg::SOUTH_W-1:0]  south_coins;
	logic [mrg_pkg::PICK_W-1:0]   fallback_pick;

	modport source(output valid, operation, east_coins, south_coins, fallback_pick,
		input ready);
	modport sink(input valid, operation, east_coins, south_coins, fallback_pick,
		output ready);
endinterface

interface mrg_out_if;
	logic                         valid;
	logic                         ready;
	logic [mrg_pkg::EAST_W-1:0]   east_open;
	logic [mrg_pkg::SOUTH_W-1:0]  south_open;

	modport source(output valid, east_open, south_open, input ready);
	modport sink(input valid, east_open, south_open, output ready);
endinterface

>>> src/mrg_ctrl.sv
// mrg_ctrl: sequencer of the row generator; walks the column passes.
// Depends on mrg_pkg; drives mrg_datapath through ctrl_cmd_t / dp_status_t.
module mrg_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  mrg_pkg::dp_status_t  status,
	output mrg_pkg::ctrl_cmd_t   cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_FRESH,
		S_EAST,
		S_JOIN,
		S_SOUTH,
		S_MOD,
		S_OUT
	} state_t;

	localparam logic [mrg_pkg::CNT_W-1:0] LAST_COL  = mrg_pkg::CNT_W'(mrg_pkg::COLUMNS - 1);
	localparam logic [mrg_pkg::CNT_W-1:0] LAST_WALL = mrg_pkg::CNT_W'(mrg_pkg::COLUMNS - 2);

	state_t                     state_q;
	logic [mrg_pkg::CNT_W-1:0]  col_q;
	logic [mrg_pkg::CNT_W-1:0]  east_next;

	assign east_next = col_q + (status.merge ? mrg_pkg::CNT_W'(2) : mrg_pkg::CNT_W'(1));
	assign in_ready  = (state_q == S_IDLE);

	always_comb begin
		cmd.col  = col_q;
		cmd.code = mrg_pkg::CMD_NONE;
		case (state_q)
			S_IDLE:  if (in_valid) cmd.code = mrg_pkg::CMD_LOAD;
			S_FRESH: cmd.code = mrg_pkg::CMD_FRESH;
			S_EAST:  cmd.code = mrg_pkg::CMD_EAST;
			S_JOIN:  cmd.code = mrg_pkg::CMD_JOIN;
			S_SOUTH: cmd.code = mrg_pkg::CMD_SOUTH;
			S_MOD:   cmd.code = mrg_pkg::CMD_MOD;
			S_OUT:   if (status.out_free) cmd.code = mrg_pkg::CMD_FINISH;
			default: cmd.code = mrg_pkg::CMD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			col_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_FRESH;
						col_q   <= '0;
					end
				end
				S_FRESH: begin
					if (status.first_row || col_q == LAST_COL) begin
						state_q <= S_EAST;
						col_q   <= '0;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				S_EAST: begin
					if (east_next > LAST_WALL) begin
						state_q <= status.last_row ? S_JOIN : S_SOUTH;
						col_q   <= '0;
					end else begin
						col_q <= east_next;
					end
				end
				S_JOIN: begin
					if (col_q == LAST_WALL) state_q <= S_OUT;
					else col_q <= col_q + 1'b1;
				end
				S_SOUTH: begin
					if (status.fallback) state_q <= S_MOD;
					else if (col_q == LAST_COL) state_q <= S_OUT;
					else col_q <= col_q + 1'b1;
				end
				S_MOD: begin
					if (!status.mod_ge) begin
						if (col_q == LAST_COL) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_SOUTH;
							col_q   <= col_q + 1'b1;
						end
					end
				end
				S_OUT: begin
					if (status.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> src/mrg_datapath.sv
// mrg_datapath: column labels, previous-row openings, carving accumulators and
// the output register. Depends on mrg_pkg; sequenced by mrg_ctrl.
module mrg_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mrg_pkg::ctrl_cmd_t            cmd,
	output mrg_pkg::dp_status_t           status,
	input  logic [mrg_pkg::OP_W-1:0]      operation,
	input  logic [mrg_pkg::EAST_W-1:0]    east_coins,
	input  logic [mrg_pkg::SOUTH_W-1:0]   south_coins,
	input  logic [mrg_pkg::PICK_W-1:0]    fallback_pick,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [mrg_pkg::EAST_W-1:0]    east_open,
	output logic [mrg_pkg::SOUTH_W-1:0]   south_open
);

	localparam int N = mrg_pkg::COLUMNS;

	logic [mrg_pkg::LAB_W-1:0]  labels_q [N];
	logic [N-1:0]               open_below_q;
	logic [N-1:0]               used_q;
	logic [mrg_pkg::OP_W-1:0]   op_q;
	logic [N-2:0]               east_c_q;
	logic [N-1:0]               south_c_q;
	logic [mrg_pkg::PICK_W-1:0] pick_q;
	logic [N-2:0]               east_q;
	logic [N-1:0]               south_q;
	logic [mrg_pkg::CNT_W-1:0]  start_q;
	logic                       any_q;
	logic [mrg_pkg::MOD_W-1:0]  rem_q;
	logic [mrg_pkg::CNT_W-1:0]  len_q;
	logic                       out_valid_q;

	logic [mrg_pkg::LAB_W-1:0]  idx;
	logic [mrg_pkg::LAB_W-1:0]  idx_nx;
	logic                       at_last;
	logic                       differ;
	logic                       run_end;
	logic                       run_any;
	logic [N-1:0]               used_init;
	logic [mrg_pkg::LAB_W-1:0]  fresh;
	logic [mrg_pkg::LAB_W-1:0]  fb_idx;
	logic [mrg_pkg::CNT_W-1:0]  run_len;

	assign idx     = cmd.col[mrg_pkg::LAB_W-1:0];
	assign at_last = (cmd.col == mrg_pkg::CNT_W'(N - 1));
	assign idx_nx  = at_last ? idx : idx + 1'b1;
	assign differ  = (labels_q[idx] != labels_q[idx_nx]);
	assign run_end = at_last || differ;
	assign run_any = any_q || south_c_q[idx];
	assign run_len = cmd.col - start_q + 1'b1;
	assign fb_idx  = mrg_pkg::LAB_W'(start_q + mrg_pkg::CNT_W'(rem_q));

	// labels still carried down from the previous row
	always_comb begin
		used_init = '0;
		for (int k = 0; k < N; k++) begin
			if (open_below_q[k]) used_init[labels_q[k]] = 1'b1;
		end
	end

	// smallest unused label, the top label when all lower ones are taken
	always_comb begin
		fresh = mrg_pkg::LAB_W'(N - 1);
		for (int k = N - 2; k >= 0; k--) begin
			if (!used_q[k]) fresh = mrg_pkg::LAB_W'(k);
		end
	end

	always_comb begin
		status.first_row = (op_q == mrg_pkg::OP_FIRST);
		status.last_row  = (op_q == mrg_pkg::OP_LAST);
		status.merge     = differ && !at_last &&
			((cmd.code == mrg_pkg::CMD_JOIN) || east_c_q[idx]);
		status.fallback  = run_end && !run_any;
		status.mod_ge    = (mrg_pkg::MOD_W'(rem_q) >= mrg_pkg::MOD_W'(len_q));
		status.out_free  = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < N; k++) labels_q[k] <= mrg_pkg::LAB_W'(k);
			open_below_q <= '0;
			op_q         <= mrg_pkg::OP_FIRST;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (cmd.code)
				mrg_pkg::CMD_LOAD: begin
					op_q      <= operation;
					east_c_q  <= mrg_pkg::widen_east(east_coins);
					south_c_q <= mrg_pkg::widen_south(south_coins);
					pick_q    <= fallback_pick;
					east_q    <= '0;
					south_q   <= '0;
					start_q   <= '0;
					any_q     <= 1'b0;
					used_q    <= used_init;
					if (operation == mrg_pkg::OP_FIRST) begin
						for (int k = 0; k < N; k++) labels_q[k] <= mrg_pkg::LAB_W'(k);
					end
				end
				mrg_pkg::CMD_FRESH: begin
					if (op_q != mrg_pkg::OP_FIRST && !open_below_q[idx]) begin
						labels_q[idx]  <= fresh;
						used_q[fresh]  <= 1'b1;
					end
				end
				mrg_pkg::CMD_EAST, mrg_pkg::CMD_JOIN: begin
					if (status.merge) begin
						east_q[idx] <= 1'b1;
						for (int k = 0; k < N; k++) begin
							if (labels_q[k] == labels_q[idx_nx]) labels_q[k] <= labels_q[idx];
						end
					end
				end
				mrg_pkg::CMD_SOUTH: begin
					if (south_c_q[idx]) south_q[idx] <= 1'b1;
					if (!run_end) begin
						any_q <= run_any;
					end else if (run_any) begin
						start_q <= cmd.col + 1'b1;
						any_q   <= 1'b0;
					end else begin
						rem_q <= mrg_pkg::MOD_W'(pick_q);
						len_q <= run_len;
					end
				end
				mrg_pkg::CMD_MOD: begin
					// remainder by repeated subtraction, one step a cycle
					if (status.mod_ge) begin
						rem_q <= rem_q - mrg_pkg::MOD_W'(len_q);
					end else begin
						south_q[fb_idx] <= 1'b1;
						start_q         <= cmd.col + 1'b1;
						any_q           <= 1'b0;
					end
				end
				mrg_pkg::CMD_FINISH: begin
					open_below_q <= south_q;
					east_open    <= mrg_pkg::narrow_east(east_q);
					south_open   <= mrg_pkg::narrow_south(south_q);
					out_valid_q  <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> src/maze_row_generator_core.sv
// maze_row_generator_core: top level of the Eller maze row generator.
// Depends on mrg_pkg, mrg_if, mrg_ctrl and mrg_datapath.
//
// One row request in, one carved row out. A row passes through a load step,
// label assignment column by column (cut short for a first row), east
// carving wall by wall (a merge skips the next wall), then either joining
// wall by wall (last row) or south carving column by column with a pick
// mod run length subtraction loop for every run that needs a forced
// opening, and a final step that hands the row to the output register,
// which waits until that register is free. Each pass walks one column or
// wall per cycle, the south pass pausing for each subtraction loop; a merge
// relabels the whole set in its cycle. A new request is taken as soon as the
// previous row sits in the output register.
module maze_row_generator_core (
	input  logic       clk,
	input  logic       arst_n,
	mrg_in_if.sink     row_in,
	mrg_out_if.source  row_out
);

	mrg_pkg::ctrl_cmd_t  cmd;
	mrg_pkg::dp_status_t status;

	mrg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (row_in.valid),
		.in_ready (row_in.ready),
		.status   (status),
		.cmd      (cmd)
	);

	mrg_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.operation     (row_in.operation),
		.east_coins    (row_in.east_coins),
		.south_coins   (row_in.south_coins),
		.fallback_pick (row_in.fallback_pick),
		.out_valid     (row_out.valid),
		.out_ready     (row_out.ready),
		.east_open     (row_out.east_open),
		.south_open    (row_out.south_open)
	);

endmodule
